@@ rtl/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_WIDTH + 1 + 7) / 8) * 8;
  localparam int SQ_W        = VALUE_WIDTH + 2;
  localparam int CNT_W       = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    KIND_NOT_PRIME,
    KIND_PRIME,
    KIND_TEST
  } kind_t;

  typedef struct packed {
    value_t value;
    kind_t  kind;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

@@ rtl/tdpt_front.sv @@
// ----------------------------------------------------------------------------
// tdpt_front
// Accepts candidates and sorts out the trivial ones before queueing.
// ----------------------------------------------------------------------------
module tdpt_front
  import tdpt_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // candidate
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  value_t n;

  assign n         = in_tdata[VALUE_WIDTH-1:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.value = n;
    priority if (n < VALUE_WIDTH'(2)) begin
      q_item.kind = KIND_NOT_PRIME;
    end else if (n == VALUE_WIDTH'(2) || n == VALUE_WIDTH'(3)) begin
      q_item.kind = KIND_PRIME;
    end else if (!n[0]) begin
      q_item.kind = KIND_NOT_PRIME;
    end else begin
      q_item.kind = KIND_TEST;
    end
  end

endmodule

@@ rtl/tdpt_queue.sv @@
// ----------------------------------------------------------------------------
// tdpt_queue
// Short queue between the front and the division engine.
// ----------------------------------------------------------------------------
module tdpt_queue
  import tdpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t pop_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/tdpt_back.sv @@
// ----------------------------------------------------------------------------
// tdpt_back
// Trial division engine with a bit-serial remainder unit and output register.
// ----------------------------------------------------------------------------
module tdpt_back
  import tdpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // tested_value, is_prime
);

  back_state_t            state_r, state_nxt;
  value_t                 value_r, value_nxt;
  value_t                 sh_r, sh_nxt;
  value_t                 d_r, d_nxt;
  value_t                 rem_r, rem_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   prime_r, prime_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   out_free;
  logic                   sq_over;
  logic                   last_step;
  logic [VALUE_WIDTH:0]   trial;
  logic                   trial_ge;
  value_t                 step_rem;

  assign out_free  = !out_valid_r || out_tready;
  assign sq_over   = (sq_r > SQ_W'(value_r));
  assign last_step = (cnt_r == CNT_W'(VALUE_WIDTH - 1));
  assign trial     = {rem_r, sh_r[VALUE_WIDTH-1]};
  assign trial_ge  = (trial >= {1'b0, d_r});
  assign step_rem  = trial_ge ? VALUE_WIDTH'(trial - {1'b0, d_r}) : trial[VALUE_WIDTH-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.kind == KIND_TEST) ? B_CHECK : B_DONE;
        end
      end
      B_CHECK: begin
        state_nxt = sq_over ? B_DONE : B_DIV;
      end
      B_DIV: begin
        if (last_step) begin
          state_nxt = (step_rem == '0) ? B_DONE : B_CHECK;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    value_nxt     = value_r;
    sh_nxt        = sh_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    sq_nxt        = sq_r;
    cnt_nxt       = cnt_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          value_nxt = q_item.value;
          prime_nxt = (q_item.kind == KIND_PRIME);
          d_nxt     = VALUE_WIDTH'(3);
          sq_nxt    = SQ_W'(9);
        end
      end
      B_CHECK: begin
        if (sq_over) begin
          prime_nxt = 1'b1;
        end else begin
          rem_nxt = '0;
          sh_nxt  = value_r;
          cnt_nxt = '0;
        end
      end
      B_DIV: begin
        rem_nxt = step_rem;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          if (step_rem == '0) begin
            prime_nxt = 1'b0;
          end else begin
            d_nxt  = d_r + VALUE_WIDTH'(2);
            sq_nxt = sq_r + {d_r, 2'b00} + SQ_W'(4);
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({prime_r, value_r});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    sh_r       <= sh_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    sq_r       <= sq_nxt;
    cnt_r      <= cnt_nxt;
    prime_r    <= prime_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < d_r))
    else $error("remainder not below divisor");

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CHECK) |-> d_r[0])
    else $error("even trial divisor");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == B_DONE))
    else $error("result loaded outside done state");

  a_sq_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CHECK) |-> (sq_r == SQ_W'(d_r) * SQ_W'(d_r)))
    else $error("running square out of step with divisor");

endmodule

@@ rtl/trial_division_prime_test_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Primality test of unsigned candidates by trial division.
// ----------------------------------------------------------------------------
// in channel:  one candidate per request in in_tdata[15:0].
// out channel: one result per candidate, in order; out_tdata[15:0] echoes the
//   candidate and out_tdata[16] is set when it is prime.
// the front sorts out values below four and even values at once and queues
// every candidate (two entries); the back tries odd divisors from three while
// the divisor squared stays at or below the candidate, each divisor through a
// one-bit-per-cycle remainder unit.
// steps: a trivial value passes from the idle state straight to the done
//   state; an odd candidate passes through the check state and the remainder
//   unit once per divisor, up to (sqrt(n) - 1) / 2 divisors, until a divisor
//   divides it or its square exceeds the candidate. the next candidate is
//   popped in the idle state after the done state loads the previous result.
// reset: synchronous, active low; clears the queue, the engine state and the
//   output valid flag.
// stall: a held result keeps the engine waiting; the queue keeps accepting
//   until its two entries are full, then in_tready drops.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
  import tdpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // candidate
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // tested_value, is_prime
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  item_t push_item;
  item_t pop_item;

  tdpt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  tdpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  tdpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
